/* sv/hrrl_pkg.sv */
// ----------------------------------------------------------------------------
// hrrl_pkg: shared types and constants
// Word formats and opcodes for the three-replica ring lookup.
// ----------------------------------------------------------------------------
package hrrl_pkg;

  localparam int unsigned IdxW       = 5;
  localparam int unsigned CodeW      = 9;
  localparam int unsigned CntW       = 6;
  localparam int unsigned MaxMembers = 32;
  localparam int unsigned Replicas   = 3;

  // Opcodes of an input word
  localparam logic [1:0] OpWrite    = 2'd0;
  localparam logic [1:0] OpSetCount = 2'd1;
  localparam logic [1:0] OpLookup   = 2'd2;
  localparam logic [1:0] OpUnused   = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IdxW-1:0]  entry_index;
    logic [CodeW-1:0] hash_code;
    logic [CntW-1:0]  member_count;
    logic [CodeW-1:0] position;
  } hrrl_in_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] second_index;
    logic [IdxW-1:0] third_index;
  } hrrl_out_t;

  // Search engine status toward the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } hrrl_status_t;

endpackage

/* sv/hrrl_search.sv */
// ----------------------------------------------------------------------------
// hrrl_search: member code table and lookup sequencer
// Holds the code table and walks it with one shared comparator.
// ----------------------------------------------------------------------------
module hrrl_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  hrrl_pkg::hrrl_in_t            item_i,
  input  logic [hrrl_pkg::CntW-1:0]     count_i,
  input  logic                          take_i,
  output hrrl_pkg::hrrl_status_t        status_o,
  output hrrl_pkg::hrrl_out_t           result_o
);

  typedef enum logic [2:0] {
    SIdle,
    SLow,
    SHigh,
    SWalk,
    SDone
  } state_e;

  state_e state_q;

  logic [hrrl_pkg::CodeW-1:0] mem_q [hrrl_pkg::MaxMembers];
  logic [hrrl_pkg::CodeW-1:0] rdata_q;
  logic [hrrl_pkg::IdxW-1:0]  raddr;
  logic                       wr_en;

  logic [hrrl_pkg::CodeW-1:0] pos_q;
  logic [hrrl_pkg::IdxW-1:0]  idx_q;
  hrrl_pkg::hrrl_out_t        res_q;

  logic                       le;
  logic                       hit;
  logic [hrrl_pkg::IdxW-1:0]  first_sel;
  logic [hrrl_pkg::CntW-1:0]  sum1;
  logic [hrrl_pkg::CntW-1:0]  sum2;
  logic [hrrl_pkg::CntW-1:0]  diff2;
  logic [hrrl_pkg::IdxW-1:0]  sec_idx;
  logic [hrrl_pkg::IdxW-1:0]  third_idx;
  logic [hrrl_pkg::IdxW-1:0]  last_idx;
  logic                       enough;

  // Table write on an accepted write-code word
  assign wr_en = start_i && (item_i.opcode == hrrl_pkg::OpWrite) &&
                 ({1'b0, item_i.entry_index} < hrrl_pkg::CntW'(hrrl_pkg::MaxMembers));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[item_i.entry_index] <= item_i.hash_code;
    end
    rdata_q <= mem_q[raddr];
  end

  // Shared comparator: position at or below the code just read
  assign le = (pos_q <= rdata_q);

  assign last_idx = hrrl_pkg::IdxW'(count_i - hrrl_pkg::CntW'(1));
  assign enough   = (count_i >= hrrl_pkg::CntW'(hrrl_pkg::Replicas));

  // Hit detection and read address per step
  always_comb begin
    hit   = 1'b0;
    raddr = '0;
    unique case (state_q)
      SIdle: begin
        raddr = '0;
      end
      SLow: begin
        hit   = le;
        raddr = last_idx;
      end
      SHigh: begin
        hit   = ~le;
        raddr = hrrl_pkg::IdxW'(1);
      end
      SWalk: begin
        hit   = le;
        raddr = idx_q + hrrl_pkg::IdxW'(1);
      end
      SDone: begin
        raddr = '0;
      end
      default: begin
        hit   = 1'b0;
        raddr = '0;
      end
    endcase
  end

  // Following replicas wrap modulo the count
  assign first_sel = (state_q == SWalk) ? idx_q : '0;
  assign sum1      = {1'b0, first_sel} + hrrl_pkg::CntW'(1);
  assign sum2      = {1'b0, first_sel} + hrrl_pkg::CntW'(2);
  assign diff2     = sum2 - count_i;
  assign sec_idx   = (sum1 == count_i) ? '0 : sum1[hrrl_pkg::IdxW-1:0];
  assign third_idx = (sum2 >= count_i) ? diff2[hrrl_pkg::IdxW-1:0]
                                       : sum2[hrrl_pkg::IdxW-1:0];

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pos_q   <= '0;
      idx_q   <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (start_i) begin
            pos_q <= item_i.position;
            if ((item_i.opcode == hrrl_pkg::OpLookup) && enough) begin
              state_q <= SLow;
            end else begin
              res_q   <= '0;
              state_q <= SDone;
            end
          end
        end
        SLow, SHigh, SWalk: begin
          if (hit) begin
            res_q   <= '{found: 1'b1, first_index: first_sel,
                         second_index: sec_idx, third_index: third_idx};
            state_q <= SDone;
          end else if (state_q == SHigh) begin
            idx_q   <= hrrl_pkg::IdxW'(1);
            state_q <= SWalk;
          end else if (state_q == SLow) begin
            state_q <= SHigh;
          end else begin
            idx_q <= idx_q + hrrl_pkg::IdxW'(1);
          end
        end
        SDone: begin
          if (take_i) begin
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign status_o.idle      = (state_q == SIdle);
  assign status_o.res_valid = (state_q == SDone);
  assign result_o           = res_q;

  // Walk never runs past the last member
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWalk) |-> ({1'b0, idx_q} < count_i))
    else $error("walk index beyond member count");

  // A found result names three distinct members
  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SDone) && res_q.found) |->
      ((res_q.first_index != res_q.second_index) &&
       (res_q.second_index != res_q.third_index) &&
       (res_q.first_index != res_q.third_index)))
    else $error("replica indices not distinct");

  // A held result stays put until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SDone) && !take_i) |=> ((state_q == SDone) && $stable(res_q)))
    else $error("result changed before it was taken");

  // Start only arrives while idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == SIdle))
    else $error("start while busy");

endmodule

/* sv/hash_ring_replica_lookup.sv */
// ----------------------------------------------------------------------------
// hash_ring_replica_lookup: three-replica consistent-hashing ring lookup
// Stores sorted member codes and a count; answers lookups with three indices.
// ----------------------------------------------------------------------------
// One word is taken at a time. Write-code, set-count and unused-opcode words,
// and lookups with fewer than three members, go straight to the result with
// found clear. A lookup reads the code table through its single registered
// read port, one entry a cycle, and compares each code against the position
// with one comparator: it checks member 0 first, then the last member (a
// position above it wraps to member 0), then walks up from member 1 to the
// first member whose code is at or above the position. The result sits in an
// output register, so the next word is accepted while it waits to be taken.
module hash_ring_replica_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hrrl_pkg::hrrl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrrl_pkg::hrrl_out_t out_data_o
);

  logic                      accept;
  logic                      take;
  logic [hrrl_pkg::CntW-1:0] count_q;
  logic                      out_valid_q;
  hrrl_pkg::hrrl_out_t       out_q;
  hrrl_pkg::hrrl_status_t    status;
  hrrl_pkg::hrrl_out_t       result;

  assign in_ready_o = status.idle;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = status.res_valid && (!out_valid_q || out_ready_i);

  hrrl_search u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .item_i   (in_data_i),
    .count_i  (count_q),
    .take_i   (take),
    .status_o (status),
    .result_o (result)
  );

  // Member count, saturated to the table depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept && (in_data_i.opcode == hrrl_pkg::OpSetCount)) begin
      if (in_data_i.member_count > hrrl_pkg::CntW'(hrrl_pkg::MaxMembers)) begin
        count_q <= hrrl_pkg::CntW'(hrrl_pkg::MaxMembers);
      end else begin
        count_q <= in_data_i.member_count;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        out_q       <= result;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
